FILE: hw/rtl/smp_pkg.sv
// Shared constants and control types for the paired sliding-window median filter.
package smp_pkg;

	localparam int WINDOW_DEF       = 8;
	localparam int SAMPLE_WIDTH_DEF = 48;
	localparam int HELD_WIDTH       = 4;
	localparam int K_WIDTH          = 5;

	typedef struct packed {
		logic               load;
		logic               step;
		logic [K_WIDTH-1:0] k;
	} ctrl_t;

endpackage

FILE: hw/rtl/smp_cell.sv
// One window cell: holds a sample, passes a circulating copy on, and counts its rank.
module smp_cell #(
	parameter int SAMPLE_WIDTH = smp_pkg::SAMPLE_WIDTH_DEF,
	parameter int RW           = 3,
	parameter int IDX          = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  smp_pkg::ctrl_t                 ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] v_in,
	input  logic                           vld_in,
	input  logic signed [SAMPLE_WIDTH-1:0] c_in,
	input  logic                           cvld_in,
	output logic signed [SAMPLE_WIDTH-1:0] v,
	output logic                           vld,
	output logic signed [SAMPLE_WIDTH-1:0] c,
	output logic                           cvld,
	output logic [RW-1:0]                  rank
);

	localparam logic [smp_pkg::K_WIDTH-1:0] IDX_K = smp_pkg::K_WIDTH'(IDX);

	logic signed [SAMPLE_WIDTH-1:0] v_q;
	logic signed [SAMPLE_WIDTH-1:0] c_q;
	logic                           vld_q;
	logic                           cvld_q;
	logic [RW-1:0]                  rank_q;
	logic                           less;

	assign less = cvld_in && ((c_in < v_q) || ((c_in == v_q) && (ctrl.k <= IDX_K)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			cvld_q <= 1'b0;
		end else if (ctrl.load) begin
			vld_q  <= vld_in;
			cvld_q <= vld_in;
		end else if (ctrl.step) begin
			cvld_q <= cvld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q    <= v_in;
			c_q    <= v_in;
			rank_q <= '0;
		end else if (ctrl.step) begin
			c_q <= c_in;
			if (less) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	assign v    = v_q;
	assign vld  = vld_q;
	assign c    = c_q;
	assign cvld = cvld_q;
	assign rank = rank_q;

endmodule

FILE: hw/rtl/smp_chain.sv
// Row of window cells for one sample stream, with selection of the middle pair by rank.
module smp_chain #(
	parameter int WINDOW       = smp_pkg::WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smp_pkg::SAMPLE_WIDTH_DEF,
	parameter int RW           = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  smp_pkg::ctrl_t                 ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic [RW-1:0]                  lo_t,
	input  logic [RW-1:0]                  hi_t,
	output logic signed [SAMPLE_WIDTH-1:0] lo_val,
	output logic signed [SAMPLE_WIDTH-1:0] hi_val
);

	logic signed [SAMPLE_WIDTH-1:0] v_w   [WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] c_w   [WINDOW];
	logic                           vld_w [WINDOW];
	logic                           cvld_w[WINDOW];
	logic [RW-1:0]                  rank_w[WINDOW];

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		smp_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.RW          (RW),
			.IDX         (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.v_in   ((i == 0) ? sample : v_w[(i + WINDOW - 1) % WINDOW]),
			.vld_in ((i == 0) ? 1'b1 : vld_w[(i + WINDOW - 1) % WINDOW]),
			.c_in   (c_w[(i + WINDOW - 1) % WINDOW]),
			.cvld_in(cvld_w[(i + WINDOW - 1) % WINDOW]),
			.v      (v_w[i]),
			.vld    (vld_w[i]),
			.c      (c_w[i]),
			.cvld   (cvld_w[i]),
			.rank   (rank_w[i])
		);
	end

	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (vld_w[i] && (rank_w[i] == lo_t)) begin
				lo_val = lo_val | v_w[i];
			end
			if (vld_w[i] && (rank_w[i] == hi_t)) begin
				hi_val = hi_val | v_w[i];
			end
		end
	end

endmodule

FILE: hw/rtl/smp_mean.sv
// Registered mean of two signed values, truncated toward zero.
module smp_mean #(
	parameter int SAMPLE_WIDTH = smp_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] a,
	input  logic signed [SAMPLE_WIDTH-1:0] b,
	output logic signed [SAMPLE_WIDTH-1:0] mean
);

	logic signed [SAMPLE_WIDTH:0] sum;
	logic signed [SAMPLE_WIDTH:0] adj;
	logic signed [SAMPLE_WIDTH-1:0] mean_q;

	assign sum = {a[SAMPLE_WIDTH-1], a} + {b[SAMPLE_WIDTH-1], b};
	assign adj = sum + {{SAMPLE_WIDTH{1'b0}}, sum[SAMPLE_WIDTH]};

	always_ff @(posedge clk) begin
		if (en) begin
			mean_q <= adj[SAMPLE_WIDTH:1];
		end
	end

	assign mean = mean_q;

endmodule

FILE: hw/rtl/sliding_window_median_pair_top.sv
// Paired sliding-window median filter: two rows of ranking cells and a shared controller.
// From the accepting edge, which loads the cells, to result valid an item passes through
// WINDOW-1 rank steps while the copies circulate round the cell ring, then select and mean.
// A new item is taken only in idle, after the rank rotation, select and mean of the last one.
// A result waiting in the output register delays only the mean step of the next item.
// Reset clears the fill count, cell valid bits and output valid; samples are not cleared.
module sliding_window_median_pair_top #(
	parameter int WINDOW       = smp_pkg::WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smp_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      offset_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]      rtt_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [smp_pkg::HELD_WIDTH-1:0]      samples_held,
	output logic                                converged,
	output logic signed [SAMPLE_WIDTH-1:0]      offset_median,
	output logic signed [SAMPLE_WIDTH-1:0]      rtt_median
);

	localparam int RW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [CW-1:0] FULL = CW'(WINDOW);
	localparam logic [smp_pkg::K_WIDTH-1:0] K_LAST = smp_pkg::K_WIDTH'(WINDOW - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RANK = 4'b0010,
		S_SEL  = 4'b0100,
		S_MEAN = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [smp_pkg::K_WIDTH-1:0]    k_q;
	logic [CW-1:0]                  fill_q;
	logic                           out_valid_q;
	logic [CW-1:0]                  held_q;
	logic                           conv_q;
	smp_pkg::ctrl_t                 ctrl;
	logic                           accept;
	logic                           mean_go;
	logic [CW-1:0]                  half;
	logic [RW-1:0]                  hi_t;
	logic [RW-1:0]                  lo_t;
	logic signed [SAMPLE_WIDTH-1:0] off_lo;
	logic signed [SAMPLE_WIDTH-1:0] off_hi;
	logic signed [SAMPLE_WIDTH-1:0] rtt_lo;
	logic signed [SAMPLE_WIDTH-1:0] rtt_hi;
	logic signed [SAMPLE_WIDTH-1:0] off_lo_s1;
	logic signed [SAMPLE_WIDTH-1:0] off_hi_s1;
	logic signed [SAMPLE_WIDTH-1:0] rtt_lo_s1;
	logic signed [SAMPLE_WIDTH-1:0] rtt_hi_s1;
	logic [CW+smp_pkg::HELD_WIDTH-1:0] held_ext;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign mean_go  = (state_q == S_MEAN) && (!out_valid_q || out_ready);

	assign ctrl.load = accept;
	assign ctrl.step = (state_q == S_RANK);
	assign ctrl.k    = k_q;

	assign half = fill_q >> 1;
	assign hi_t = half[RW-1:0];
	assign lo_t = fill_q[0] ? hi_t : (hi_t - RW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q <= smp_pkg::K_WIDTH'(1);
						if (fill_q != FULL) begin
							fill_q <= fill_q + CW'(1);
						end
						state_q <= (WINDOW > 1) ? S_RANK : S_SEL;
					end
				end
				S_RANK: begin
					if (k_q == K_LAST) begin
						state_q <= S_SEL;
					end else begin
						k_q <= k_q + smp_pkg::K_WIDTH'(1);
					end
				end
				S_SEL: begin
					state_q <= S_MEAN;
				end
				S_MEAN: begin
					if (mean_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEL) begin
			off_lo_s1 <= off_lo;
			off_hi_s1 <= off_hi;
			rtt_lo_s1 <= rtt_lo;
			rtt_hi_s1 <= rtt_hi;
		end
		if (mean_go) begin
			held_q <= fill_q;
			conv_q <= (fill_q == FULL);
		end
	end

	smp_chain #(
		.WINDOW      (WINDOW),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.RW          (RW)
	) u_off_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.sample(offset_sample),
		.lo_t  (lo_t),
		.hi_t  (hi_t),
		.lo_val(off_lo),
		.hi_val(off_hi)
	);

	smp_chain #(
		.WINDOW      (WINDOW),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.RW          (RW)
	) u_rtt_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.sample(rtt_sample),
		.lo_t  (lo_t),
		.hi_t  (hi_t),
		.lo_val(rtt_lo),
		.hi_val(rtt_hi)
	);

	smp_mean #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_off_mean (
		.clk (clk),
		.en  (mean_go),
		.a   (off_lo_s1),
		.b   (off_hi_s1),
		.mean(offset_median)
	);

	smp_mean #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_rtt_mean (
		.clk (clk),
		.en  (mean_go),
		.a   (rtt_lo_s1),
		.b   (rtt_hi_s1),
		.mean(rtt_median)
	);

	assign held_ext     = {{smp_pkg::HELD_WIDTH{1'b0}}, held_q};
	assign samples_held = held_ext[smp_pkg::HELD_WIDTH-1:0];
	assign converged    = conv_q;
	assign out_valid    = out_valid_q;

`ifndef SYNTHESIS
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while another is still being ranked");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count beyond window depth");

	a_mean_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEAN) && out_valid_q && !out_ready |=> (state_q == S_MEAN) && out_valid_q)
		else $error("pending result overwritten");

	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (held_q != '0))
		else $error("result with empty window");
`endif

endmodule
